// ===== rtl/rlph_pkg.sv =====
// ----------------------------------------------------------------------------
// rlph_pkg
// Shared types and constants for the range line parser with history.
// ----------------------------------------------------------------------------
package rlph_pkg;

	// Frame limits for the valid flag.
	localparam logic [15:0] DIST_MIN = 16'd20;
	localparam logic [15:0] DIST_MAX = 16'd10000;
	localparam logic [15:0] CONF_MAX = 16'd1000;

	// Characters that the parser treats specially.
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Result status codes.
	localparam logic [1:0] ST_STORED    = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_NO_COMMA  = 2'd2;

	// Configuration register indexes (selected by paddr[2]).
	localparam logic REG_ACTIVE_CHANNELS = 1'b0;
	localparam logic REG_LINK_READY      = 1'b1;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] confidence;
		logic [15:0] distance;
	} frame_t;

	// Parser view of the line so far, handed to the frame store.
	typedef struct packed {
		logic        comma_seen;
		logic [15:0] first_number;
		logic [15:0] number;
	} parse_t;

	typedef struct packed {
		logic [2:0]  history_slot;
		logic        frame_valid;
		logic [15:0] confidence;
		logic [15:0] distance;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic [2:0] active_channels;
		logic       link_ready;
	} cfg_t;

endpackage

// ===== rtl/rlph_parser.sv =====
// ----------------------------------------------------------------------------
// rlph_parser
// Per-byte text parser: comma split and strtoul-style number reading.
// ----------------------------------------------------------------------------
module rlph_parser import rlph_pkg::*; #(
	parameter int LINE_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output parse_t     parse
);

	localparam int CC_W = $clog2(LINE_BYTES);
	localparam logic [CC_W-1:0] CC_LIMIT = CC_W'(LINE_BYTES - 1);

	logic [CC_W-1:0] char_count_q, char_count_d;
	logic            text_ended_q, text_ended_d;
	logic            comma_seen_q, comma_seen_d;
	phase_t          phase_q, phase_d;
	logic            negative_q, negative_d;
	logic [31:0]     acc_q, acc_d;
	logic            saturated_q, saturated_d;
	logic [15:0]     first_q, first_d;

	logic [15:0] number;
	logic        is_digit;
	logic        is_space;
	logic [35:0] acc_next;
	logic [3:0]  digit;

	always_comb begin
		if (saturated_q) begin
			number = 16'hFFFF;
		end else if (negative_q) begin
			number = 16'd0 - acc_q[15:0];
		end else begin
			number = acc_q[15:0];
		end
	end

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
	assign digit    = text_byte[3:0];
	// Ten times the accumulator as two shifts, plus the new digit.
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, digit};

	always_comb begin
		char_count_d = char_count_q;
		text_ended_d = text_ended_q;
		comma_seen_d = comma_seen_q;
		phase_d      = phase_q;
		negative_d   = negative_q;
		acc_d        = acc_q;
		saturated_d  = saturated_q;
		first_d      = first_q;
		if (step && line_end) begin
			char_count_d = '0;
			text_ended_d = 1'b0;
			comma_seen_d = 1'b0;
			phase_d      = PH_SKIP;
			negative_d   = 1'b0;
			acc_d        = '0;
			saturated_d  = 1'b0;
			first_d      = '0;
		end else if (step && !text_ended_q && (char_count_q < CC_LIMIT)) begin
			if (text_byte == CH_NUL) begin
				text_ended_d = 1'b1;
			end else begin
				char_count_d = char_count_q + 1'b1;
				if (!comma_seen_q && (text_byte == CH_COMMA)) begin
					first_d      = number;
					comma_seen_d = 1'b1;
					phase_d      = PH_SKIP;
					negative_d   = 1'b0;
					acc_d        = '0;
					saturated_d  = 1'b0;
				end else begin
					unique case (phase_q)
						PH_SKIP: begin
							if (is_space) begin
								phase_d = PH_SKIP;
							end else if ((text_byte == CH_PLUS) || (text_byte == CH_MINUS)) begin
								negative_d = (text_byte == CH_MINUS);
								phase_d    = PH_SIGN;
							end else if (is_digit) begin
								phase_d = PH_DIGITS;
							end else begin
								phase_d = PH_DONE;
							end
						end
						PH_SIGN, PH_DIGITS: begin
							phase_d = is_digit ? PH_DIGITS : PH_DONE;
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
					// A digit is taken in every phase except once the number is done or saturated.
					if (is_digit && (phase_q != PH_DONE) && !saturated_q) begin
						if (acc_next[35:32] != 4'd0) begin
							saturated_d = 1'b1;
						end else begin
							acc_d = acc_next[31:0];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			text_ended_q <= 1'b0;
			comma_seen_q <= 1'b0;
			phase_q      <= PH_SKIP;
			negative_q   <= 1'b0;
			acc_q        <= '0;
			saturated_q  <= 1'b0;
			first_q      <= '0;
		end else begin
			char_count_q <= char_count_d;
			text_ended_q <= text_ended_d;
			comma_seen_q <= comma_seen_d;
			phase_q      <= phase_d;
			negative_q   <= negative_d;
			acc_q        <= acc_d;
			saturated_q  <= saturated_d;
			first_q      <= first_d;
		end
	end

	assign parse.comma_seen   = comma_seen_q;
	assign parse.first_number = first_q;
	assign parse.number       = number;

endmodule

// ===== rtl/rlph_store.sv =====
// ----------------------------------------------------------------------------
// rlph_store
// Per-channel ring heads and latest frames; builds the line result.
// ----------------------------------------------------------------------------
module rlph_store import rlph_pkg::*; #(
	parameter int CHANNELS = 4,
	parameter int HISTORY  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_done,
	input  logic [7:0] channel,
	input  cfg_t       cfg,
	input  parse_t     parse,
	output result_t    result
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HD_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam logic [2:0]      CH_CAP   = 3'((CHANNELS > 7) ? 7 : CHANNELS);
	localparam logic [HD_W-1:0] HEAD_TOP = HD_W'(HISTORY - 1);

	logic [HD_W-1:0] ring_heads_q [CHANNELS];
	frame_t          latest_q     [CHANNELS];

	logic [2:0]      count;
	logic            in_range;
	logic            store;
	logic [IDX_W-1:0] idx;
	logic [HD_W-1:0] head;
	logic [HD_W-1:0] head_next;
	frame_t          frame;

	assign count    = (cfg.active_channels > CH_CAP) ? CH_CAP : cfg.active_channels;
	assign in_range = channel < {5'd0, count};
	assign idx      = channel[IDX_W-1:0];
	assign store    = cfg.link_ready && in_range && parse.comma_seen;
	assign head     = ring_heads_q[idx];
	assign head_next = (head == HEAD_TOP) ? '0 : head + 1'b1;

	assign frame.distance   = parse.first_number;
	assign frame.confidence = parse.number;
	assign frame.valid      = (parse.first_number >= DIST_MIN) &&
	                          (parse.first_number <= DIST_MAX) &&
	                          (parse.number <= CONF_MAX);

	always_comb begin
		if (!cfg.link_ready || !in_range) begin
			result.status = ST_NOT_READY;
		end else if (!parse.comma_seen) begin
			result.status = ST_NO_COMMA;
		end else begin
			result.status = ST_STORED;
		end
		if (!in_range) begin
			result.distance    = '0;
			result.confidence  = '0;
			result.frame_valid = 1'b0;
		end else if (store) begin
			result.distance    = frame.distance;
			result.confidence  = frame.confidence;
			result.frame_valid = frame.valid;
		end else begin
			result.distance    = latest_q[idx].distance;
			result.confidence  = latest_q[idx].confidence;
			result.frame_valid = latest_q[idx].valid;
		end
		result.history_slot = store ? 3'(head) : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ring_heads_q[i] <= '0;
				latest_q[i]     <= '0;
			end
		end else if (line_done && store) begin
			ring_heads_q[idx] <= head_next;
			latest_q[idx]     <= frame;
		end
	end

endmodule

// ===== rtl/range_line_parser_history.sv =====
// ----------------------------------------------------------------------------
// range_line_parser_history
// Range-sensor line parser with per-channel ring position and latest frame.
// ----------------------------------------------------------------------------
// The block takes one text byte per input transfer and accepts a transfer in
// every cycle while the result side is not stalled. A transfer first lands in
// an input register; from there the parser updates its line state and, for a
// transfer with tlast set, the frame store forms the result, which is held in
// an output register that drives m_tvalid. One item passes per cycle; only a
// line end waits, while an earlier result has not been taken. The per-cycle
// work is bounded by the accumulator update, a 36-bit add of the shifted
// accumulator and the digit. Byte transfers (tlast low) give no result; every
// tlast transfer gives exactly one. Configuration must be written over the
// APB port only while no line end is in flight; the block does not enforce
// it. The active channel count is at address 0 and link_ready at address 4
// (only paddr[2] is decoded).
// ----------------------------------------------------------------------------
module range_line_parser_history import rlph_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int HISTORY    = 8,
	parameter int LINE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] text_byte, [15:8] channel
	input  logic        s_tlast,   // line_end
	// Master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] status, [17:2] distance, [33:18] confidence,
	                               // [34] frame_valid, [37:35] history_slot, [39:38] zero
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	cfg_t cfg_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic [7:0] channel_s1;
	logic       line_end_s1;

	// Output stage.
	logic    valid_s2;
	result_t result_s2;

	logic    advance;
	logic    line_done;
	parse_t  parse;
	result_t result;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_ACTIVE_CHANNELS: cfg_q.active_channels <= pwdata[2:0];
				REG_LINK_READY:      cfg_q.link_ready      <= pwdata[0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE_CHANNELS: prdata = {29'd0, cfg_q.active_channels};
			REG_LINK_READY:      prdata = {31'd0, cfg_q.link_ready};
			default:             prdata = '0;
		endcase
	end

	// The staged item moves on unless it is a line end and the output
	// register still holds a result that has not been taken.
	assign advance   = valid_s1 && (!line_end_s1 || !valid_s2 || m_tready);
	assign line_done = advance && line_end_s1;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			text_byte_s1 <= s_tdata[7:0];
			channel_s1   <= s_tdata[15:8];
			line_end_s1  <= s_tlast;
		end
	end

	rlph_parser #(
		.LINE_BYTES (LINE_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (text_byte_s1),
		.line_end  (line_end_s1),
		.parse     (parse)
	);

	rlph_store #(
		.CHANNELS (CHANNELS),
		.HISTORY  (HISTORY)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_done (line_done),
		.channel   (channel_s1),
		.cfg       (cfg_q),
		.parse     (parse),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (line_done) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_done) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, result_s2};

	// A ready result side never stalls the input.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output side was ready");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_s2.status == ST_STORED || result_s2.status == ST_NOT_READY ||
		              result_s2.status == ST_NO_COMMA))
		else $error("undefined status code");

	// A ring slot is reported only for a stored frame.
	a_slot_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.status != ST_STORED) |-> (result_s2.history_slot == 3'd0))
		else $error("history slot reported for a line that stored nothing");

	// A valid frame lies within the distance and confidence limits.
	a_frame_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.frame_valid) |->
		(result_s2.distance >= DIST_MIN && result_s2.distance <= DIST_MAX &&
		 result_s2.confidence <= CONF_MAX))
		else $error("frame marked valid outside its limits");

	// A line end leaves a result in the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		line_done |=> m_tvalid)
		else $error("line end produced no result");

endmodule

// ===== bench/range_line_parser_history_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_line_parser_history_checker
// Watches the stream and APB ports of the line parser, keeps its own copy of
// the parser and frame state, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module range_line_parser_history_checker import rlph_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int HISTORY    = 8,
	parameter int LINE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] text_byte, [15:8] channel
	input  logic        s_tlast,   // line_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [1:0] status, [17:2] distance, [33:18] confidence,
	                               // [34] frame_valid, [37:35] history_slot, [39:38] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	// Configuration copy.
	logic [2:0]  cfg_count;
	logic        cfg_link;

	// Line parsing state.
	int unsigned char_count;
	logic        text_ended;
	logic        comma_seen;
	phase_t      phase;
	logic        negative;
	logic [31:0] accum;
	logic        saturated;
	logic [15:0] first_num;

	// Frame store.
	frame_t      latest [CHANNELS];
	int unsigned ring_head [CHANNELS];

	result_t     expected_results [$];

	initial errors = 0;
	initial pending = 0;

	task automatic clear_number();
		phase = PH_SKIP;
		negative = 1'b0;
		accum = '0;
		saturated = 1'b0;
	endtask

	task automatic clear_line();
		char_count = 0;
		text_ended = 1'b0;
		comma_seen = 1'b0;
		first_num = '0;
		clear_number();
	endtask

	function automatic logic [15:0] number_value();
		logic [31:0] v;
		if (saturated) begin
			v = 32'hFFFF_FFFF;
		end else if (negative) begin
			v = 32'd0 - accum;
		end else begin
			v = accum;
		end
		return v[15:0];
	endfunction

	task automatic add_digit(input logic [7:0] c);
		logic [63:0] t;
		if (!saturated) begin
			t = {32'd0, accum} * 64'd10 + {56'd0, c - CH_ZERO};
			if (t > 64'h0000_0000_FFFF_FFFF) begin
				saturated = 1'b1;
			end else begin
				accum = t[31:0];
			end
		end
	endtask

	task automatic parse_byte(input logic [7:0] c);
		logic digit;
		logic space;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		if (!text_ended && char_count < LINE_BYTES - 1) begin
			if (c == CH_NUL) begin
				text_ended = 1'b1;
			end else begin
				char_count++;
				if (!comma_seen && c == CH_COMMA) begin
					first_num = number_value();
					comma_seen = 1'b1;
					clear_number();
				end else begin
					case (phase)
						PH_SKIP: begin
							if (space) begin
								// Leading whitespace is skipped.
							end else if (c == CH_PLUS || c == CH_MINUS) begin
								negative = (c == CH_MINUS);
								phase = PH_SIGN;
							end else if (digit) begin
								add_digit(c);
								phase = PH_DIGITS;
							end else begin
								phase = PH_DONE;
							end
						end
						PH_SIGN, PH_DIGITS: begin
							if (digit) begin
								add_digit(c);
								phase = PH_DIGITS;
							end else begin
								phase = PH_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	endtask

	task automatic close_line(input logic [7:0] ch);
		int unsigned count;
		logic        in_range;
		result_t     r;
		frame_t      f;
		count = (cfg_count > CHANNELS) ? CHANNELS : cfg_count;
		in_range = ch < count;
		r = '0;
		if (!cfg_link || count == 0 || !in_range) begin
			r.status = ST_NOT_READY;
		end else if (!comma_seen) begin
			r.status = ST_NO_COMMA;
		end else begin
			f.distance = first_num;
			f.confidence = number_value();
			f.valid = (f.distance >= DIST_MIN) && (f.distance <= DIST_MAX) &&
				(f.confidence <= CONF_MAX);
			latest[ch] = f;
			r.history_slot = 3'(ring_head[ch]);
			ring_head[ch] = (ring_head[ch] + 1) % HISTORY;
			r.status = ST_STORED;
		end
		if (in_range) begin
			r.distance = latest[ch].distance;
			r.confidence = latest[ch].confidence;
			r.frame_valid = latest[ch].valid;
		end
		expected_results.push_back(r);
		clear_line();
	endtask

	task automatic report_mismatch(input string what, input logic [39:0] got,
		input logic [39:0] want);
		$display("checker: %s mismatch at %0t: got %0h, expected %0h", what, $time, got, want);
		errors++;
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got = m_tdata[37:0];
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result", m_tdata, '0);
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.distance !== want.distance)
				report_mismatch("distance", got.distance, want.distance);
			if (got.confidence !== want.confidence)
				report_mismatch("confidence", got.confidence, want.confidence);
			if (got.frame_valid !== want.frame_valid)
				report_mismatch("frame_valid", got.frame_valid, want.frame_valid);
			if (got.history_slot !== want.history_slot)
				report_mismatch("history_slot", got.history_slot, want.history_slot);
			if (m_tdata[39:38] !== 2'b00)
				report_mismatch("padding", m_tdata[39:38], 2'b00);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count = '0;
			cfg_link = 1'b0;
			clear_line();
			for (int i = 0; i < CHANNELS; i++) begin
				latest[i] = '0;
				ring_head[i] = 0;
			end
			expected_results.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				if (s_tlast) begin
					close_line(s_tdata[15:8]);
				end else begin
					parse_byte(s_tdata[7:0]);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LINK_READY) begin
					cfg_link = pwdata[0];
				end else begin
					cfg_count = pwdata[2:0];
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== bench/range_line_parser_history_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_line_parser_history_tb
// Drives sensor lines and register settings into the line parser and reports
// the verdict of the checker that runs beside it.
// ----------------------------------------------------------------------------
// A short directed part covers the not-ready state after reset, the frame
// limits, signs and a bad channel. The random part then runs through several
// register settings, the extremes among them, and feeds mostly well-formed
// lines with random numbers, whitespace and signs, mixed with overlong lines,
// text cut by a zero byte, extra commas, lines without a comma and raw noise.
// Both handshake sides idle at random, apart from one phase with no idling.
// ----------------------------------------------------------------------------
module range_line_parser_history_tb import rlph_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 260;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int          errors;
	int          pending;
	int          cycles = 0;
	int          sent_items = 0;
	// While steady is set neither side idles.
	bit          steady = 1'b0;

	range_line_parser_history dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	range_line_parser_history_checker checker_i (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.errors, .pending
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The run is cut off if it hangs, for instance on a lost result.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("range_line_parser_history_tb: done, errors");
			$finish;
		end
	end

	// The result side stalls in about a third of the cycles.
	always @(negedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
	end

	// One slave-side transfer. It is entered at a falling edge and returns
	// at the falling edge after the transfer was taken.
	task automatic send_xfer(input logic [7:0] text_byte, input logic line_end,
		input logic [7:0] channel);
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {channel, text_byte};
		s_tlast <= line_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// The channel field of a byte transfer is ignored, so it carries noise.
	task automatic send_byte(input logic [7:0] c);
		send_xfer(c, 1'b0, 8'($urandom()));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// The text byte of a line end is ignored, so it carries noise.
	task automatic end_line(input logic [7:0] channel);
		send_xfer(8'($urandom()), 1'b1, channel);
	endtask

	// Waits until every expected result has come, then lets the pipeline
	// settle after any trailing byte transfers.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The block only sees the low bits of each register, so the upper bits
	// of the write data carry noise.
	task automatic set_config(input logic [2:0] count, input logic link);
		drain();
		apb_write(REG_ACTIVE_CHANNELS, ($urandom() & ~32'h7) | {29'd0, count});
		apb_write(REG_LINK_READY, ($urandom() & ~32'h1) | {31'd0, link});
	endtask

	function automatic logic [7:0] pick_channel();
		return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 4)) :
			8'($urandom_range(0, 255));
	endfunction

	// Decimal text of a number, aimed at the frame limits, at 16-bit wrap
	// and at 32-bit saturation.
	function automatic string number_text();
		int unsigned v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom_range(0, 30);
			3:       v = $urandom_range(9990, 10010);
			4:       v = $urandom_range(990, 1010);
			5, 6:    v = $urandom_range(0, 65535);
			7:       v = $urandom();
			8: begin
				case ($urandom_range(0, 2))
					0: return "4294967295";
					1: return "4294967296";
					default: return "99999999999";
				endcase
			end
			default: begin
				if ($urandom_range(0, 1) == 0) return "";
				return $sformatf("000%0d", $urandom_range(0, 999));
			end
		endcase
		return $sformatf("%0d", v);
	endfunction

	// Optional whitespace and sign, then the digits of one number.
	task automatic send_number();
		logic [7:0] blanks [6];
		blanks = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
		repeat ($urandom_range(0, 2)) send_byte(blanks[$urandom_range(0, 5)]);
		case ($urandom_range(0, 9))
			0: send_byte(CH_PLUS);
			1, 2: send_byte(CH_MINUS);
			3: begin
				// A second sign is a non-digit and ends the number.
				send_byte(CH_PLUS);
				send_byte(CH_MINUS);
			end
			default: begin
			end
		endcase
		send_text(number_text());
	endtask

	task automatic random_line();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			send_number();
			send_byte(CH_COMMA);
			send_number();
			case ($urandom_range(0, 9))
				0: begin
					// Only the first comma splits the line.
					send_byte(CH_COMMA);
					send_text(number_text());
				end
				1: begin
					// The zero byte ends the text; what follows is ignored.
					send_byte(CH_NUL);
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
				end
				2: send_text(" mm");
				3: begin
					// Push the line past the byte limit.
					repeat ($urandom_range(10, 30))
						send_byte(($urandom_range(0, 3) == 0) ? CH_COMMA :
							8'(CH_ZERO + $urandom_range(0, 9)));
				end
				default: begin
				end
			endcase
		end else if (kind < 85) begin
			send_number();
			if ($urandom_range(0, 1) == 0) send_text(" x");
		end else if (kind < 95) begin
			repeat ($urandom_range(0, 10)) send_byte(8'($urandom()));
		end else if (kind < 98) begin
			// A comma hidden behind an early zero byte does not count.
			send_text("12");
			send_byte(CH_NUL);
			send_text(",34");
		end
		end_line(pick_channel());
	endtask

	initial begin
		logic [2:0] counts [7];
		logic       links [7];
		int         goal;
		counts = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd4};
		links  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Right after reset the block is not ready.
		send_text("12,34");
		end_line(8'd0);
		set_config(3'd4, 1'b1);
		// Both frame limits hit exactly.
		send_text("20,1000");
		end_line(8'd0);
		// A negated distance wraps; a plus sign is accepted.
		send_text(" -1,+65535");
		end_line(8'd3);
		// Channel far out of range.
		send_text("5");
		end_line(8'd255);
		// Extra comma with empty numbers on both sides.
		send_text(",,");
		end_line(8'd1);

		// Random part, one phase per register setting. The sender waits for
		// every result at each change of setting.
		for (int p = 0; p < 7; p++) begin
			set_config(counts[p], links[p]);
			steady = (p == 2);
			goal = sent_items + PHASE_ITEMS;
			while (sent_items < goal) random_line();
		end
		steady = 1'b0;

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("range_line_parser_history_tb: done, clean");
		end else begin
			$display("range_line_parser_history_tb: done, errors");
		end
		$finish;
	end

endmodule
